// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the dispatcher top level.
// Depends on nothing; the using module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rrtd_pkg.sv -----
// Types and constants of the round-robin task dispatcher.
// No dependencies.
package rrtd_pkg;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_TICK     = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_RUN_DONE = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  slot;
        logic        present;
        logic        ready_req;
        logic        queue_blocked;
        logic        sem_blocked;
        logic [15:0] delay;
        logic [7:0]  counter_value;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [3:0]  selected_slot;
        logic [31:0] elapsed;
        logic [31:0] slot_time;
        logic [31:0] total_time;
    } t_rsp;

    // one slot entry of the task table
    typedef struct packed {
        logic        present;
        logic        ready;
        logic        queue_blocked;
        logic        sem_blocked;
        logic [15:0] delay;
    } t_attr;

    localparam t_attr ATTR_RESET = '{present: 1'b0, ready: 1'b1, queue_blocked: 1'b0,
                                     sem_blocked: 1'b0, delay: 16'd0};
    localparam logic [7:0] TOP_RESET = 8'hFF;

    function automatic logic runnable(input t_attr a);
        runnable = a.present && a.ready && !a.queue_blocked && !a.sem_blocked
                   && (a.delay == 16'd0);
    endfunction

endpackage

// ----- hw/rtl/rrtd_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on rrtd_pkg.
interface rrtd_req_if;
    import rrtd_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rrtd_rsp_if;
    import rrtd_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rrtd_slot_table.sv -----
// Slot attribute memory: one read and one write port, registered read data.
// Entries never written read back as the reset entry. Depends on rrtd_pkg.
module rrtd_slot_table #(
    parameter int NUM_SLOTS = 16,
    parameter int IW        = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [IW-1:0]     i_rd_addr,
    output rrtd_pkg::t_attr   o_rd_data,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  rrtd_pkg::t_attr   i_wr_data
);
    import rrtd_pkg::*;

    t_attr                r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    t_attr                r_rdata;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : ATTR_RESET;

endmodule

// ----- hw/rtl/round_robin_task_dispatcher_unit.sv -----
// Round-robin task dispatcher top level: sequencer, execution-time memory.
// Depends on rrtd_pkg, rrtd_if, rrtd_slot_table and assert_macros.svh.
//
//  channel  | dir | handshake            | payload
//  i_req    | in  | valid/ready          | op, slot, marks, delay, counter_value
//  o_rsp    | out | valid/ready          | found, selected_slot, elapsed, times
//  cfg      | in  | i_cfg_we             | timer_top
//
// One item at a time, in these states: write S_WR, S_RDX, S_XW, S_OUT;
// tick S_TICK over every slot, then S_RDX, S_XW, S_OUT; run done S_MUL,
// S_EL, S_ACC, S_OUT; dispatch S_DA0, S_DA1, S_DRD and S_DCHK per candidate
// tried (at most NUM_SLOTS), then S_RDX, S_XW, S_OUT; S_IDLE takes the next item.
// Reset is synchronous; the tables need no clearing pass.
// A result waits in the output register while the next item is taken; the
// sequencer only stalls when a second result is ready before the first leaves.
module round_robin_task_dispatcher_unit #(
    parameter int NUM_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrtd_req_if.sink   i_req,
    rrtd_rsp_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);
    import rrtd_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_WR   = 13'b0000000000010,
        S_TICK = 13'b0000000000100,
        S_DA0  = 13'b0000000001000,
        S_DA1  = 13'b0000000010000,
        S_DRD  = 13'b0000000100000,
        S_DCHK = 13'b0000001000000,
        S_MUL  = 13'b0000010000000,
        S_EL   = 13'b0000100000000,
        S_RDX  = 13'b0001000000000,
        S_XW   = 13'b0010000000000,
        S_ACC  = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state          r_state;
    t_req            r_req;
    logic [7:0]      r_top;
    logic [IW-1:0]   r_cur;
    logic [15:0]     r_ticks;
    logic [7:0]      r_start;
    logic [31:0]     r_total;
    logic [IW:0]     r_idx;
    logic            r_pend;
    logic [IW-1:0]   r_waddr;
    logic [IW-1:0]   r_cand;
    logic [IW-1:0]   r_nxt;
    logic            r_wrap;
    logic [IW-1:0]   r_cnt;
    t_attr           r_a0;
    logic            r_found;
    logic [24:0]     r_prod;
    logic [31:0]     r_el;
    logic [31:0]     r_stime;
    logic            r_ov;
    logic            n_ov;
    t_rsp            r_rsp;

    // execution-time memory
    logic [31:0]          r_xmem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_xvld;
    logic [31:0]          r_xrd;
    logic                 r_xrv;
    logic [31:0]          xdata;
    logic [31:0]          xsum;
    logic                 x_rd_en;
    logic                 x_wr_en;

    // slot table port
    logic          t_rd_en;
    logic [IW-1:0] t_rd_addr;
    t_attr         t_rd_data;
    logic          t_wr_en;
    logic [IW-1:0] t_wr_addr;
    t_attr         t_wr_data;

    logic [IW:0]   nxt_full;
    t_attr         rec;
    logic          use_a0;
    logic [IW-1:0] cand_eff;
    logic          out_free;
    logic          acc_in;
    logic          slot_ok;

    assign acc_in   = i_req.valid && i_req.ready;
    assign out_free = !r_ov || o_rsp.ready;
    assign n_ov     = ((r_state == S_OUT) && out_free) || (r_ov && !o_rsp.ready);
    assign slot_ok  = 32'(r_req.slot) < NUM_SLOTS;
    assign nxt_full = (IW+1)'(r_cand) + (IW+1)'(1);
    assign use_a0   = r_wrap || !t_rd_data.present;
    assign rec      = use_a0 ? r_a0 : t_rd_data;
    assign cand_eff = use_a0 ? '0 : r_nxt;
    assign xdata    = r_xrv ? r_xrd : 32'd0;
    assign xsum     = xdata + r_el;

    rrtd_slot_table #(.NUM_SLOTS(NUM_SLOTS), .IW(IW)) u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (t_rd_en),
        .i_rd_addr (t_rd_addr),
        .o_rd_data (t_rd_data),
        .i_wr_en   (t_wr_en),
        .i_wr_addr (t_wr_addr),
        .i_wr_data (t_wr_data)
    );

    always_comb begin
        t_rd_en   = 1'b0;
        t_rd_addr = '0;
        t_wr_en   = 1'b0;
        t_wr_addr = r_waddr;
        t_wr_data = t_rd_data;
        case (r_state)
            S_WR: begin
                t_wr_en   = slot_ok;
                t_wr_addr = IW'(r_req.slot);
                t_wr_data = '{present: r_req.present, ready: r_req.ready_req,
                              queue_blocked: r_req.queue_blocked,
                              sem_blocked: r_req.sem_blocked, delay: r_req.delay};
            end
            S_TICK: begin
                t_rd_en   = r_idx < (IW+1)'(NUM_SLOTS);
                t_rd_addr = r_idx[IW-1:0];
                // write back the entry read last cycle, decremented
                t_wr_en   = r_pend && (t_rd_data.delay != 16'd0);
                t_wr_data.delay = t_rd_data.delay - 16'd1;
            end
            S_DA0: begin
                t_rd_en = 1'b1;
            end
            S_DRD: begin
                t_rd_en   = nxt_full < (IW+1)'(NUM_SLOTS);
                t_rd_addr = nxt_full[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    assign x_rd_en = (r_state == S_RDX) || (r_state == S_EL);
    assign x_wr_en = (r_state == S_ACC);

    always_ff @(posedge i_clk) begin
        if (x_wr_en) begin
            r_xmem[r_cur] <= xsum;
        end
        if (x_rd_en) begin
            r_xrd <= r_xmem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= TOP_RESET;
            r_cur   <= IW'(NUM_SLOTS - 1);
            r_ticks <= '0;
            r_start <= '0;
            r_total <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_wrap  <= 1'b0;
            r_found <= 1'b0;
            r_ov    <= 1'b0;
            r_xvld  <= '0;
            r_xrv   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_top <= i_cfg_wdata;
            end
            r_ov <= n_ov;
            if (x_wr_en) begin
                r_xvld[r_cur] <= 1'b1;
            end
            if (x_rd_en) begin
                r_xrv <= r_xvld[r_cur];
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_cnt   <= '0;
                        r_cand  <= r_cur;
                        case (i_req.data.op)
                            OP_WRITE:    r_state <= S_WR;
                            OP_TICK:     r_state <= S_TICK;
                            OP_DISPATCH: r_state <= S_DA0;
                            OP_RUN_DONE: r_state <= S_MUL;
                            default:     r_state <= S_WR;
                        endcase
                    end
                end
                S_WR: begin
                    r_state <= S_RDX;
                end
                S_TICK: begin
                    r_waddr <= r_idx[IW-1:0];
                    if (r_idx < (IW+1)'(NUM_SLOTS)) begin
                        r_idx  <= r_idx + (IW+1)'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_ticks <= r_ticks + 16'd1;
                        r_state <= S_RDX;
                    end
                end
                S_DA0: begin
                    r_state <= S_DA1;
                end
                S_DA1: begin
                    r_a0    <= t_rd_data;
                    r_state <= S_DRD;
                end
                S_DRD: begin
                    r_nxt   <= nxt_full[IW-1:0];
                    r_wrap  <= !(nxt_full < (IW+1)'(NUM_SLOTS));
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    if (runnable(rec)) begin
                        r_found <= 1'b1;
                        r_cur   <= cand_eff;
                        r_ticks <= '0;
                        r_start <= r_req.counter_value;
                        r_state <= S_RDX;
                    end else begin
                        r_cand <= cand_eff;
                        r_cnt  <= r_cnt + IW'(1);
                        if (r_cnt == IW'(NUM_SLOTS - 1)) begin
                            r_state <= S_RDX;
                        end else begin
                            r_state <= S_DRD;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_EL;
                end
                S_EL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_total <= r_total + r_el;
                    r_state <= S_OUT;
                end
                S_RDX: begin
                    r_state <= S_XW;
                end
                S_XW: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_req <= i_req.data;
            r_el  <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= 25'(r_ticks) * 25'({1'b0, r_top} + 9'd1);
        end
        if (r_state == S_EL) begin
            r_el <= 32'(r_prod) + 32'(r_req.counter_value) - 32'(r_start);
        end
        if (r_state == S_ACC) begin
            r_stime <= xsum;
        end
        if (r_state == S_XW) begin
            r_stime <= xdata;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_rsp.found         <= r_found;
            r_rsp.selected_slot <= 4'(r_cur);
            r_rsp.elapsed       <= r_el;
            r_rsp.slot_time     <= r_stime;
            r_rsp.total_time    <= r_total;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_leaves_idle, acc_in, r_state != S_IDLE, "item accepted but sequencer idle")
    `ASSERT_NOW(a_found_only_dispatch, (r_state == S_OUT) && r_found, r_req.op == OP_DISPATCH, "found set outside dispatch")
    `ASSERT_NOW(a_walk_bound, 1'b1, r_idx <= (IW+1)'(NUM_SLOTS), "tick walk index past table")
    `ASSERT_NOW(a_elapsed_run_done, (r_state == S_OUT) && (r_el != 32'd0), r_req.op == OP_RUN_DONE, "elapsed set outside run done")

endmodule
